@@ hdl/tlfs_pkg.sv @@
// ----------------------------------------------------------------------------
// tlfs_pkg
// Shared types and constants for the two-level feedback scheduler.
// ----------------------------------------------------------------------------
package tlfs_pkg;

    localparam int TASK_W        = 4;
    localparam int CMD_W         = 3;
    localparam int QUANT_W       = 8;
    localparam int MAX_TASKS_DEF = 16;

    localparam logic [QUANT_W-1:0] LONG_QUANTUM_RST = 8'd1;
    localparam logic [QUANT_W-1:0] HIGH_QUANTUM     = 8'd1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UNBLOCK = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BLOCK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EXIT    = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the accepted item
        logic execute;   // apply the item and load the result register
    } tlfs_ctrl_t;

endpackage

@@ hdl/two_level_feedback_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// two_level_feedback_scheduler_top
// Single-core two-level feedback scheduler with high and low task FIFOs.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------
//   input    | in_valid / in_stall | cmd, task_id
//   output   | out_valid/out_stall | running_task, idle, overflow
//   config   | cfg_we              | cfg_data (long quantum)
//
// Each item is accepted, then applied, which loads the result register. The
// execute step waits for the registered read of the two queue RAMs, which
// present their head entries in the cycle after acceptance.
// A new item is taken while the previous result still waits downstream;
// a stalled output holds the item in execution until the result drains.
// Reset clears both queues, selects the idle task and sets long quantum 1.
// ----------------------------------------------------------------------------
module two_level_feedback_scheduler_top
    import tlfs_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // input item
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [TASK_W-1:0]  task_id,
    // result item
    output logic               out_valid,
    input  logic               out_stall,
    output logic [TASK_W-1:0]  running_task,
    output logic               idle,
    output logic               overflow,
    // long quantum register
    input  logic               cfg_we,
    input  logic [QUANT_W-1:0] cfg_data
);

    tlfs_ctrl_t ctrl;

    // sequence each item and own the output handshake
    tlfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctrl      (ctrl)
    );

    // queues, running task and quantum bookkeeping
    tlfs_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .cmd          (cmd),
        .task_id      (task_id),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .running_task (running_task),
        .idle         (idle),
        .overflow     (overflow)
    );

endmodule

@@ hdl/tlfs_ram.sv @@
// ----------------------------------------------------------------------------
// tlfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlfs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/tlfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// tlfs_ctrl
// Item sequencer: accept, execute, and result register handshake.
// ----------------------------------------------------------------------------
module tlfs_ctrl
    import tlfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    output tlfs_ctrl_t ctrl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;
    logic done;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    // finish only when the result register is free or drains this cycle
    assign done     = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign ctrl.capture = accept;
    assign ctrl.execute = done;

endmodule

@@ hdl/tlfs_datapath.sv @@
// ----------------------------------------------------------------------------
// tlfs_datapath
// Queue pointers, running task, quantum counter and result register.
// ----------------------------------------------------------------------------
module tlfs_datapath
    import tlfs_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tlfs_ctrl_t         ctrl,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [TASK_W-1:0]  task_id,
    input  logic               cfg_we,
    input  logic [QUANT_W-1:0] cfg_data,
    output logic [TASK_W-1:0]  running_task,
    output logic               idle,
    output logic               overflow
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_TASKS);
    localparam logic [CNT_W:0]   SUM_WRAP = (CNT_W + 1)'(MAX_TASKS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_TASKS - 1);

    // captured item
    logic [CMD_W-1:0]  cmd_reg;
    logic [TASK_W-1:0] id_reg;

    // scheduler state
    logic [CNT_W-1:0]   high_count_reg, high_count_next;
    logic [IDX_W-1:0]   high_head_reg,  high_head_next;
    logic [CNT_W-1:0]   low_count_reg,  low_count_next;
    logic [IDX_W-1:0]   low_head_reg,   low_head_next;
    logic [TASK_W-1:0]  cur_task_reg,   cur_task_next;
    logic               cur_idle_reg,   cur_idle_next;
    logic [QUANT_W-1:0] quantum_reg,    quantum_next;
    logic [QUANT_W-1:0] long_q_reg;

    // result register
    logic [TASK_W-1:0] res_task_reg;
    logic              res_idle_reg;
    logic              res_ovf_reg;

    // queue memories
    logic              high_we, low_we;
    logic [IDX_W-1:0]  high_tail, low_tail;
    logic [TASK_W-1:0] high_rdata, low_rdata;
    logic [TASK_W-1:0] low_wdata;

    // scheduling terms
    logic [QUANT_W-1:0] q_dec;
    logic               pick_req;
    logic               pop_high, pop_low, got;
    logic [TASK_W-1:0]  nid;
    logic [QUANT_W-1:0] pick_q;
    logic [CNT_W-1:0]   low_mid_count;
    logic               ovf;

    function automatic logic [IDX_W-1:0] wrap_sum(
        input logic [IDX_W-1:0] head,
        input logic [CNT_W-1:0] count
    );
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(count);
        if (sum >= SUM_WRAP)
        begin
            sum = sum - SUM_WRAP;
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        return (idx == IDX_LAST) ? '0 : idx + 1'b1;
    endfunction

    tlfs_ram #(
        .WIDTH (TASK_W),
        .DEPTH (MAX_TASKS)
    ) u_high_ram (
        .clk   (clk),
        .we    (high_we),
        .waddr (high_tail),
        .wdata (id_reg),
        .raddr (high_head_reg),
        .rdata (high_rdata)
    );

    tlfs_ram #(
        .WIDTH (TASK_W),
        .DEPTH (MAX_TASKS)
    ) u_low_ram (
        .clk   (clk),
        .we    (low_we),
        .waddr (low_tail),
        .wdata (low_wdata),
        .raddr (low_head_reg),
        .rdata (low_rdata)
    );

    assign high_tail = wrap_sum(high_head_reg, high_count_reg);
    // after a pop the slot for a push is still head + old count
    assign low_tail  = wrap_sum(low_head_reg, low_count_reg);
    assign low_wdata = cur_task_reg;
    assign q_dec     = (quantum_reg != '0) ? quantum_reg - 1'b1 : '0;

    always_comb
    begin
        pick_req = 1'b0;
        case (cmd_reg)
            CMD_TICK:
            begin
                pick_req = (q_dec == '0);
            end
            CMD_BLOCK, CMD_EXIT:
            begin
                pick_req = 1'b1;
            end
            default:
            begin
                pick_req = 1'b0;
            end
        endcase
    end

    // pick: high head, else low head, else idle
    always_comb
    begin
        pop_high = 1'b0;
        pop_low  = 1'b0;
        got      = 1'b0;
        nid      = '0;
        pick_q   = '0;
        if (high_count_reg != '0)
        begin
            pop_high = pick_req;
            got      = 1'b1;
            nid      = high_rdata;
            pick_q   = HIGH_QUANTUM;
        end
        else if (low_count_reg != '0)
        begin
            pop_low = pick_req;
            got     = 1'b1;
            nid     = low_rdata;
            pick_q  = long_q_reg;
        end
    end

    assign low_mid_count = low_count_reg - CNT_W'(pop_low);

    always_comb
    begin
        high_count_next = high_count_reg;
        high_head_next  = high_head_reg;
        low_count_next  = low_mid_count;
        low_head_next   = pop_low ? next_idx(low_head_reg) : low_head_reg;
        cur_task_next   = cur_task_reg;
        cur_idle_next   = cur_idle_reg;
        quantum_next    = quantum_reg;
        high_we         = 1'b0;
        low_we          = 1'b0;
        ovf             = 1'b0;

        if (pop_high)
        begin
            high_count_next = high_count_reg - 1'b1;
            high_head_next  = next_idx(high_head_reg);
        end

        case (cmd_reg)
            CMD_LOAD, CMD_UNBLOCK:
            begin
                if (high_count_reg == CNT_FULL)
                begin
                    ovf = 1'b1;
                end
                else
                begin
                    high_we         = ctrl.execute;
                    high_count_next = high_count_reg + 1'b1;
                end
            end
            CMD_TICK:
            begin
                quantum_next = q_dec;
                if (pick_req)
                begin
                    quantum_next = pick_q;
                    // keep the running task when nothing waits
                    if (got || cur_idle_reg)
                    begin
                        if (!cur_idle_reg)
                        begin
                            if (low_mid_count == CNT_FULL)
                            begin
                                ovf = 1'b1;
                            end
                            else
                            begin
                                low_we         = ctrl.execute;
                                low_count_next = low_mid_count + 1'b1;
                            end
                        end
                        cur_task_next = nid;
                        cur_idle_next = !got;
                    end
                end
            end
            CMD_BLOCK, CMD_EXIT:
            begin
                quantum_next  = pick_q;
                cur_task_next = nid;
                cur_idle_next = !got;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_count_reg <= '0;
            high_head_reg  <= '0;
            low_count_reg  <= '0;
            low_head_reg   <= '0;
            cur_task_reg   <= '0;
            cur_idle_reg   <= 1'b1;
            quantum_reg    <= '0;
            long_q_reg     <= LONG_QUANTUM_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                long_q_reg <= cfg_data;
            end
            if (ctrl.execute)
            begin
                high_count_reg <= high_count_next;
                high_head_reg  <= high_head_next;
                low_count_reg  <= low_count_next;
                low_head_reg   <= low_head_next;
                cur_task_reg   <= cur_task_next;
                cur_idle_reg   <= cur_idle_next;
                quantum_reg    <= quantum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg <= cmd;
            id_reg  <= task_id;
        end
        if (ctrl.execute)
        begin
            res_task_reg <= cur_idle_next ? '0 : cur_task_next;
            res_idle_reg <= cur_idle_next;
            res_ovf_reg  <= ovf;
        end
    end

    assign running_task = res_task_reg;
    assign idle         = res_idle_reg;
    assign overflow     = res_ovf_reg;

endmodule
